// File: src/hdes_pkg.sv
// shared types, constants and helper functions of the holt smoothing block
`default_nettype none

package hdes_pkg;

  localparam int ELEMENTS      = 1024;
  localparam int IDX_W         = $clog2(ELEMENTS);
  localparam int SAMPLE_BITS   = 32;
  localparam int FRACTION_BITS = 16;

  localparam int FACTOR_W    = 17;
  localparam int FACTOR_FRAC = 16;
  localparam int FACTOR_ONE  = 1 << FACTOR_FRAC;
  localparam int FACTOR_RST  = 6554;
  localparam int HALF        = 1 << (FACTOR_FRAC - 1);

  localparam int DIFF_W = SAMPLE_BITS + 2;
  localparam int PROD_W = DIFF_W + FACTOR_W + 1;
  localparam int RND_W  = PROD_W - FACTOR_FRAC;
  localparam int SAT_W  = SAMPLE_BITS + 5;

  localparam int TDATA_W = ((IDX_W + SAMPLE_BITS + 7) / 8) * 8;
  localparam int PAD_W   = TDATA_W - IDX_W - SAMPLE_BITS;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic REG_DATA_FACTOR  = 1'b0;
  localparam logic REG_TREND_FACTOR = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [FACTOR_W-1:0]           factor_t;
  typedef logic [1:0]                    phase_t;

  localparam phase_t PH_INIT  = 2'd0;
  localparam phase_t PH_TREND = 2'd1;
  localparam phase_t PH_RUN   = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PRED,
    ST_MUL_A,
    ST_LEVEL,
    ST_DIFF,
    ST_MUL_G,
    ST_TREND,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic accept;
    logic clr_init;
    logic clr_step;
    logic rd_en;
    logic pred_en;
    logic mul_a_en;
    logic level_en;
    logic diff_en;
    logic mul_g_en;
    logic trend_en;
    logic write_en;
  } cmd_t;

  typedef struct packed {
    logic   in_clear;
    logic   in_idx_ok;
    phase_t phase;
    logic   clr_last;
    logic   out_free;
  } status_t;

  function automatic sample_t sat_s(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    sample_t                 res;
    hi = $signed({{(SAT_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      res = $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    end else if (v < lo) begin
      res = $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    end else begin
      res = $signed(v[SAMPLE_BITS-1:0]);
    end
    return res;
  endfunction

  function automatic factor_t clamp_factor(input logic [CFG_DATA_W-1:0] v);
    factor_t f;
    f = v[FACTOR_W-1:0];
    if (f > factor_t'(FACTOR_ONE)) begin
      f = factor_t'(FACTOR_ONE);
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// File: src/hdes_cfg.sv
// apb register file holding the two smoothing factors
`default_nettype none

module hdes_cfg
  import hdes_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output      logic [CFG_DATA_W-1:0] prdata,
  output      logic                  pready,
  output      factor_t               alpha_o,
  output      factor_t               gamma_o
);

  factor_t alpha_q, alpha_d;
  factor_t gamma_q, gamma_d;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    alpha_d = alpha_q;
    gamma_d = gamma_q;
    if (wr_en) begin
      if (paddr[CFG_ADDR_W-1] == REG_DATA_FACTOR) begin
        alpha_d = clamp_factor(pwdata);
      end else begin
        gamma_d = clamp_factor(pwdata);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= factor_t'(FACTOR_RST);
      gamma_q <= factor_t'(FACTOR_RST);
    end else begin
      alpha_q <= alpha_d;
      gamma_q <= gamma_d;
    end
  end

  always_comb begin
    if (paddr[CFG_ADDR_W-1] == REG_TREND_FACTOR) begin
      prdata = CFG_DATA_W'(gamma_q);
    end else begin
      prdata = CFG_DATA_W'(alpha_q);
    end
  end

  assign alpha_o = alpha_q;
  assign gamma_o = gamma_q;

endmodule

`default_nettype wire

// File: src/hdes_ctrl.sv
// controller state machine sequencing reads, arithmetic steps and writes
`default_nettype none

module hdes_ctrl
  import hdes_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    s_axis_tvalid,
  output      logic    s_axis_tready,
  input  wire status_t status_i,
  output      cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (status_i.in_clear) begin
            state_d = ST_CLEAR;
          end else if (status_i.in_idx_ok) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ:  state_d = ST_PRED;
      ST_PRED: begin
        if (status_i.phase == PH_INIT || status_i.phase == PH_TREND) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_MUL_A;
        end
      end
      ST_MUL_A: state_d = ST_LEVEL;
      ST_LEVEL: state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_MUL_G;
      ST_MUL_G: state_d = ST_TREND;
      ST_TREND: state_d = ST_WRITE;
      ST_WRITE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.accept  = s_axis_tvalid;
        cmd_o.clr_init = s_axis_tvalid & status_i.in_clear;
      end
      ST_READ:  cmd_o.rd_en    = 1'b1;
      ST_PRED:  cmd_o.pred_en  = 1'b1;
      ST_MUL_A: cmd_o.mul_a_en = 1'b1;
      ST_LEVEL: cmd_o.level_en = 1'b1;
      ST_DIFF:  cmd_o.diff_en  = 1'b1;
      ST_MUL_G: cmd_o.mul_g_en = 1'b1;
      ST_TREND: cmd_o.trend_en = 1'b1;
      ST_WRITE: cmd_o.write_en = status_i.out_free;
      default:  cmd_o          = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/hdes_datapath.sv
// element stores, smoothing arithmetic and output register
`default_nettype none

module hdes_datapath
  import hdes_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output      status_t            status_o,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,
  input  wire logic               s_axis_tuser,
  input  wire factor_t            alpha_i,
  input  wire factor_t            gamma_i,
  output      logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output      logic [TDATA_W-1:0] m_axis_tdata,
  output      logic               m_axis_tuser
);

  phase_t                   phase_mem [ELEMENTS];
  logic [2*SAMPLE_BITS-1:0] lt_mem    [ELEMENTS];

  idx_t                     idx_q;
  sample_t                  x_q;
  idx_t                     clr_cnt_q;
  phase_t                   phase_rd_q;
  logic [2*SAMPLE_BITS-1:0] lt_rd_q;

  logic signed [SAMPLE_BITS:0] pred_q;
  logic signed [DIFF_W-1:0]    diff_a_q;
  logic signed [PROD_W-1:0]    prod_a_q;
  sample_t                     nl_q;
  logic signed [DIFF_W-1:0]    diff_g_q;
  logic signed [PROD_W-1:0]    prod_g_q;
  sample_t                     nt_q;

  logic    m_valid_q;
  idx_t    m_idx_q;
  sample_t m_fc_q;
  logic    m_warm_q;

  sample_t                  lv, tr, in_x;
  idx_t                     in_idx;
  logic signed [SAMPLE_BITS:0] pred;
  logic signed [RND_W-1:0]  rnd_a, rnd_g;
  logic                     phase_we;
  idx_t                     phase_wa;
  phase_t                   phase_wd;
  logic [2*SAMPLE_BITS-1:0] lt_wd;
  sample_t                  res_fc;
  logic                     res_warm;

  assign in_idx = s_axis_tdata[IDX_W-1:0];
  assign in_x   = $signed(s_axis_tdata[IDX_W +: SAMPLE_BITS]);
  assign lv     = $signed(lt_rd_q[SAMPLE_BITS-1:0]);
  assign tr     = $signed(lt_rd_q[2*SAMPLE_BITS-1:SAMPLE_BITS]);
  assign pred   = (SAMPLE_BITS+1)'(lv) + (SAMPLE_BITS+1)'(tr);

  assign rnd_a = RND_W'((prod_a_q + $signed(PROD_W'(HALF))) >>> FACTOR_FRAC);
  assign rnd_g = RND_W'((prod_g_q + $signed(PROD_W'(HALF))) >>> FACTOR_FRAC);

  // status toward the controller
  always_comb begin
    status_o.in_clear  = s_axis_tuser;
    status_o.in_idx_ok = int'(in_idx) < ELEMENTS;
    status_o.phase     = phase_rd_q;
    status_o.clr_last  = clr_cnt_q == idx_t'(ELEMENTS - 1);
    status_o.out_free  = !m_valid_q || m_axis_tready;
  end

  // write-back selection
  always_comb begin
    phase_we = cmd_i.clr_step | cmd_i.write_en;
    phase_wa = cmd_i.clr_step ? clr_cnt_q : idx_q;
    res_fc   = x_q;
    res_warm = 1'b1;
    lt_wd    = {tr, x_q};
    phase_wd = PH_INIT;
    if (!cmd_i.clr_step) begin
      case (phase_rd_q)
        PH_INIT: begin
          phase_wd = PH_TREND;
          lt_wd    = {tr, x_q};
        end
        PH_TREND: begin
          phase_wd = PH_RUN;
          lt_wd    = {sat_s(SAT_W'(x_q) - SAT_W'(lv)), x_q};
        end
        default: begin
          phase_wd = PH_RUN;
          lt_wd    = {nt_q, nl_q};
          res_fc   = sat_s(SAT_W'(nl_q) + SAT_W'(nt_q));
          res_warm = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_we) begin
      phase_mem[phase_wa] <= phase_wd;
    end
    if (cmd_i.rd_en) begin
      phase_rd_q <= phase_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_en) begin
      lt_mem[idx_q] <= lt_wd;
    end
    if (cmd_i.rd_en) begin
      lt_rd_q <= lt_mem[idx_q];
    end
  end

  // clearing sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_init) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + idx_t'(1);
    end
  end

  // arithmetic steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q <= in_idx;
      x_q   <= in_x;
    end
    if (cmd_i.pred_en) begin
      pred_q   <= pred;
      diff_a_q <= DIFF_W'(x_q) - DIFF_W'(pred);
    end
    if (cmd_i.mul_a_en) begin
      prod_a_q <= diff_a_q * $signed({1'b0, alpha_i});
    end
    if (cmd_i.level_en) begin
      nl_q <= sat_s(SAT_W'(pred_q) + SAT_W'(rnd_a));
    end
    if (cmd_i.diff_en) begin
      diff_g_q <= DIFF_W'(nl_q) - DIFF_W'(lv) - DIFF_W'(tr);
    end
    if (cmd_i.mul_g_en) begin
      prod_g_q <= diff_g_q * $signed({1'b0, gamma_i});
    end
    if (cmd_i.trend_en) begin
      nt_q <= sat_s(SAT_W'(tr) + SAT_W'(rnd_g));
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.write_en) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_en) begin
      m_idx_q  <= idx_q;
      m_fc_q   <= res_fc;
      m_warm_q <= res_warm;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, m_fc_q, m_idx_q};
  assign m_axis_tuser  = m_warm_q;

endmodule

`default_nettype wire

// File: src/holt_double_exponential_smoothing_top.sv
// top level of the element-wise holt double exponential smoothing block
//
// Each beat on the slave stream either feeds one Q16.16 sample to one of 1024
// elements or, with tuser set, clears the history of every element. An element
// echoes its first two samples (tuser high on the result) while it sets up
// level and trend, then emits the saturated level-plus-trend forecast. One
// beat is handled at a time: a running sample goes through a registered store
// read, then two dependent multiply-and-round steps, a warm-up sample skips
// both multiply steps, and a clear sweeps the phase store one entry per cycle.
// The same sweep runs after reset, and s_axis_tready stays low until it is
// done. A finished result waits in an output register, so the next beat is
// accepted while it is still pending.
`default_nettype none

module holt_double_exponential_smoothing_top
  import hdes_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // element_index, sample
  input  wire logic [TDATA_W-1:0]    s_axis_tdata,
  // mode
  input  wire logic                  s_axis_tuser,
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_index, forecast
  output      logic [TDATA_W-1:0]    m_axis_tdata,
  // warming_up
  output      logic                  m_axis_tuser,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output      logic [CFG_DATA_W-1:0] prdata,
  output      logic                  pready
);

  cmd_t    cmd;
  status_t status;
  factor_t alpha;
  factor_t gamma;

  hdes_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .alpha_o (alpha),
    .gamma_o (gamma)
  );

  hdes_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  hdes_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .alpha_i       (alpha),
    .gamma_i       (gamma),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire
